// File: design/cpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_pkg
// Shared codes and field widths of the critical path event engine.
// ----------------------------------------------------------------------------
package cpe_pkg;

    // Fixed port field widths
    localparam int VERTEX_W    = 6;
    localparam int WEIGHT_IN_W = 16;
    localparam int CFG_W       = 6;

    // Command codes
    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_COMPUTE  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_CYCLE = 1'b1;

endpackage

`default_nettype wire

// File: design/critical_path_events.sv
`timescale 1ns / 1ps
`default_nettype none
// Add edge: an ignored edge leaves the block idle; a stored edge reads the list and
// degree tables, then writes them back.
// Compute: degree copy, topological, forward and backward list walks over every
// vertex and edge, each timed walk after its time table clear, and a critical scan.
// Results are one-cycle strobes; the receiver cannot stall them.
// Reset (rst_n low, async): vertex_count 32, all lists empty, degrees zero.
// ----------------------------------------------------------------------------
// critical_path_events
// Activity-on-edge graph store with critical path event computation.
// ----------------------------------------------------------------------------
module critical_path_events #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         cmd,
    input  wire logic [cpe_pkg::VERTEX_W-1:0] src_vertex,
    input  wire logic [cpe_pkg::VERTEX_W-1:0] dst_vertex,
    input  wire logic [cpe_pkg::WEIGHT_IN_W-1:0] edge_weight,
    input  wire logic                         cfg_we,
    input  wire logic [cpe_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                              result_strobe,
    output logic [cpe_pkg::VERTEX_W-1:0]      event_vertex,
    output logic                              status,
    output logic                              last
);

    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int VD  = MAX_VERTICES + 1;
    localparam int TAW = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int CW  = EW + 1;
    localparam int WB  = WEIGHT_BITS;
    localparam int TW  = WB + VW;
    localparam int XW  = (VW > cpe_pkg::VERTEX_W) ? VW : cpe_pkg::VERTEX_W;
    localparam int WX  = (WB > cpe_pkg::WEIGHT_IN_W) ? WB : cpe_pkg::WEIGHT_IN_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD1    = 4'd1;
    localparam logic [3:0] S_INIT_RD = 4'd2;
    localparam logic [3:0] S_INIT_WR = 4'd3;
    localparam logic [3:0] S_ORD_RD  = 4'd4;
    localparam logic [3:0] S_ORD_U   = 4'd5;
    localparam logic [3:0] S_LIST    = 4'd6;
    localparam logic [3:0] S_WALK_RD = 4'd7;
    localparam logic [3:0] S_WALK_V  = 4'd8;
    localparam logic [3:0] S_WALK_UP = 4'd9;
    localparam logic [3:0] S_EINIT   = 4'd10;
    localparam logic [3:0] S_LINIT   = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;

    // Compute passes
    localparam logic [1:0] P_TOPO = 2'd0;
    localparam logic [1:0] P_FWD  = 2'd1;
    localparam logic [1:0] P_BWD  = 2'd2;
    localparam logic [1:0] P_SCAN = 2'd3;

    logic [3:0]          state_reg;
    logic [1:0]          pass_reg;
    logic [cpe_pkg::CFG_W-1:0] vcount_reg;
    logic [CW-1:0]       used_reg;
    logic [MAX_VERTICES:0] list_valid_reg;
    logic [MAX_VERTICES:0] deg_valid_reg;
    logic [VW-1:0]       idx_reg;
    logic [VW-1:0]       tail_reg;
    logic [VW-1:0]       s_reg;
    logic [VW-1:0]       t_reg;
    logic [VW-1:0]       u_reg;
    logic [VW-1:0]       v_reg;
    logic [WB-1:0]       w_reg;
    logic                hn_reg;
    logic [EW-1:0]       nx_reg;
    logic [EW-1:0]       e_reg;
    logic [TW-1:0]       eu_reg;
    logic [TW-1:0]       lu_reg;
    logic [TW-1:0]       total_reg;
    logic [VW-1:0]       pend_reg;
    logic                pend_valid_reg;
    logic                strobe_reg;
    logic [cpe_pkg::VERTEX_W-1:0] ev_reg;
    logic                status_reg;
    logic                last_reg;

    // RAM ports
    logic               list_we;
    logic [VW-1:0]      list_waddr, list_raddr;
    logic [2*EW-1:0]    list_wdata, list_rd;
    logic               deg_we;
    logic [VW-1:0]      deg_waddr, deg_raddr;
    logic [CW-1:0]      deg_wdata, deg_rd;
    logic               data_we;
    logic [VW+WB-1:0]   data_wdata, data_rd;
    logic               link_we;
    logic [EW-1:0]      link_waddr;
    logic [EW:0]        link_wdata, link_rd;
    logic               dw_we;
    logic [VW-1:0]      dw_waddr;
    logic [CW-1:0]      dw_wdata, dw_rd;
    logic               topo_we;
    logic [TAW-1:0]     topo_waddr, topo_raddr;
    logic [VW-1:0]      topo_wdata, topo_rd;
    logic               ear_we;
    logic [VW-1:0]      ear_waddr, vt_raddr;
    logic [TW-1:0]      ear_wdata, ear_rd;
    logic               lat_we;
    logic [VW-1:0]      lat_waddr;
    logic [TW-1:0]      lat_wdata, lat_rd;

    // Derived values
    logic [VW-1:0]      n_act;
    logic [VW-1:0]      src_a, dst_a;
    logic               add_ok;
    logic               accept;
    logic [WB-1:0]      w_in;
    logic [WX-1:0]      w_ext;
    logic [EW-1:0]      list_first, list_last;
    logic [VW-1:0]      v_rd;
    logic [WB-1:0]      w_rd;
    logic               hn_rd;
    logic [EW-1:0]      nx_rd;
    logic               v_ok;
    logic [CW-1:0]      deg_eff;
    logic [TW-1:0]      cand_e, cand_l, lu_upd;
    logic [VW-1:0]      ord_addr;
    logic               push_ok;

    // Effective vertex count and edge range check
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_act = VW'(1);
        end
        else if (XW'(vcount_reg) > XW'(MAX_VERTICES))
        begin
            n_act = VW'(MAX_VERTICES);
        end
        else
        begin
            n_act = VW'(vcount_reg);
        end
    end

    assign src_a  = VW'(XW'(src_vertex));
    assign dst_a  = VW'(XW'(dst_vertex));
    assign add_ok = (src_vertex != '0) && (XW'(src_vertex) <= XW'(n_act))
                 && (dst_vertex != '0) && (XW'(dst_vertex) <= XW'(n_act))
                 && (used_reg != CW'(MAX_EDGES));
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign w_ext  = WX'(edge_weight);
    assign w_in   = w_ext[WB-1:0];

    assign list_first = list_rd[2*EW-1:EW];
    assign list_last  = list_rd[EW-1:0];
    assign v_rd   = data_rd[VW+WB-1:WB];
    assign w_rd   = data_rd[WB-1:0];
    assign hn_rd  = link_rd[EW];
    assign nx_rd  = link_rd[EW-1:0];
    assign v_ok   = (v_rd != '0) && (v_rd <= n_act);
    assign deg_eff = deg_valid_reg[idx_reg] ? deg_rd : '0;
    assign cand_e = eu_reg + TW'(w_reg);
    assign cand_l = lat_rd - TW'(w_reg);
    assign lu_upd = (cand_l < lu_reg) ? cand_l : lu_reg;
    assign ord_addr = (pass_reg == P_BWD) ? (idx_reg - VW'(1)) : idx_reg;
    assign push_ok  = (dw_rd == CW'(1)) && (tail_reg < VW'(MAX_VERTICES));

    // RAM port control
    always_comb
    begin
        list_we    = 1'b0;
        list_waddr = s_reg;
        list_wdata = list_valid_reg[s_reg] ? {list_first, used_reg[EW-1:0]}
                                           : {used_reg[EW-1:0], used_reg[EW-1:0]};
        list_raddr = (state_reg == S_IDLE) ? src_a : topo_rd;
        deg_we     = 1'b0;
        deg_waddr  = t_reg;
        deg_wdata  = (deg_valid_reg[t_reg] ? deg_rd : '0) + CW'(1);
        deg_raddr  = (state_reg == S_IDLE) ? dst_a : idx_reg;
        data_we    = 1'b0;
        data_wdata = {dst_a, w_in};
        link_we    = 1'b0;
        link_waddr = used_reg[EW-1:0];
        link_wdata = '0;
        dw_we      = 1'b0;
        dw_waddr   = idx_reg;
        dw_wdata   = deg_eff;
        topo_we    = 1'b0;
        topo_waddr = tail_reg[TAW-1:0];
        topo_wdata = idx_reg;
        topo_raddr = ord_addr[TAW-1:0];
        vt_raddr   = (state_reg == S_ORD_U) ? topo_rd : v_rd;
        ear_we     = 1'b0;
        ear_waddr  = idx_reg;
        ear_wdata  = '0;
        lat_we     = 1'b0;
        lat_waddr  = idx_reg;
        lat_wdata  = total_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == cpe_pkg::CMD_ADD_EDGE) && add_ok)
                begin
                    data_we = 1'b1;
                    link_we = 1'b1;
                end
            end
            S_ADD1:
            begin
                list_we = 1'b1;
                deg_we  = 1'b1;
                if (list_valid_reg[s_reg])
                begin
                    link_we    = 1'b1;
                    link_waddr = list_last;
                    link_wdata = {1'b1, used_reg[EW-1:0]};
                end
            end
            S_INIT_WR:
            begin
                dw_we = 1'b1;
                if (deg_eff == '0)
                begin
                    topo_we = 1'b1;
                end
            end
            S_WALK_V:
            begin
                if (!v_ok && !hn_rd && (pass_reg == P_BWD))
                begin
                    lat_we    = 1'b1;
                    lat_waddr = u_reg;
                    lat_wdata = lu_reg;
                end
            end
            S_WALK_UP:
            begin
                if (pass_reg == P_TOPO)
                begin
                    if (dw_rd != '0)
                    begin
                        dw_we    = 1'b1;
                        dw_waddr = v_reg;
                        dw_wdata = dw_rd - CW'(1);
                    end
                    if (push_ok)
                    begin
                        topo_we    = 1'b1;
                        topo_wdata = v_reg;
                    end
                end
                else if (pass_reg == P_FWD)
                begin
                    if (cand_e > ear_rd)
                    begin
                        ear_we    = 1'b1;
                        ear_waddr = v_reg;
                        ear_wdata = cand_e;
                    end
                end
                else if ((pass_reg == P_BWD) && !hn_reg)
                begin
                    lat_we    = 1'b1;
                    lat_waddr = u_reg;
                    lat_wdata = lu_upd;
                end
            end
            S_EINIT:
            begin
                ear_we = 1'b1;
            end
            S_LINIT:
            begin
                lat_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= P_TOPO;
            vcount_reg     <= cpe_pkg::CFG_W'(32);
            used_reg       <= '0;
            list_valid_reg <= '0;
            deg_valid_reg  <= '0;
            idx_reg        <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            s_reg          <= '0;
            t_reg          <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            w_reg          <= '0;
            hn_reg         <= 1'b0;
            nx_reg         <= '0;
            e_reg          <= '0;
            eu_reg         <= '0;
            lu_reg         <= '0;
            total_reg      <= '0;
            pend_reg       <= '0;
            ev_reg         <= '0;
            status_reg     <= cpe_pkg::STATUS_OK;
            last_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == cpe_pkg::CMD_COMPUTE)
                        begin
                            idx_reg   <= VW'(1);
                            tail_reg  <= '0;
                            pass_reg  <= P_TOPO;
                            state_reg <= S_INIT_RD;
                        end
                        else if (add_ok)
                        begin
                            s_reg     <= src_a;
                            t_reg     <= dst_a;
                            state_reg <= S_ADD1;
                        end
                    end
                end
                S_ADD1:
                begin
                    list_valid_reg[s_reg] <= 1'b1;
                    deg_valid_reg[t_reg]  <= 1'b1;
                    used_reg  <= used_reg + CW'(1);
                    state_reg <= S_IDLE;
                end
                // Copy in-degrees and seed zero-degree vertices
                S_INIT_RD:
                begin
                    state_reg <= S_INIT_WR;
                end
                S_INIT_WR:
                begin
                    if (deg_eff == '0)
                    begin
                        tail_reg <= tail_reg + VW'(1);
                    end
                    if (idx_reg == n_act)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_ORD_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + VW'(1);
                        state_reg <= S_INIT_RD;
                    end
                end
                // Next vertex in topological order, per pass
                S_ORD_RD:
                begin
                    unique case (pass_reg)
                        P_TOPO:
                        begin
                            if (idx_reg == tail_reg)
                            begin
                                if (idx_reg != n_act)
                                begin
                                    strobe_reg <= 1'b1;
                                    ev_reg     <= '0;
                                    status_reg <= cpe_pkg::STATUS_CYCLE;
                                    last_reg   <= 1'b1;
                                    state_reg  <= S_IDLE;
                                end
                                else
                                begin
                                    idx_reg   <= VW'(1);
                                    state_reg <= S_EINIT;
                                end
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + VW'(1);
                                state_reg <= S_ORD_U;
                            end
                        end
                        P_FWD:
                        begin
                            if (idx_reg == n_act)
                            begin
                                idx_reg   <= VW'(1);
                                state_reg <= S_LINIT;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + VW'(1);
                                state_reg <= S_ORD_U;
                            end
                        end
                        P_BWD:
                        begin
                            if (idx_reg == '0)
                            begin
                                pass_reg       <= P_SCAN;
                                pend_valid_reg <= 1'b0;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg - VW'(1);
                                state_reg <= S_ORD_U;
                            end
                        end
                        P_SCAN:
                        begin
                            if (idx_reg == n_act)
                            begin
                                if (pend_valid_reg)
                                begin
                                    strobe_reg <= 1'b1;
                                    ev_reg     <= cpe_pkg::VERTEX_W'(XW'(pend_reg));
                                    status_reg <= cpe_pkg::STATUS_OK;
                                    last_reg   <= 1'b1;
                                end
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + VW'(1);
                                state_reg <= S_ORD_U;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_ORD_U:
                begin
                    u_reg     <= topo_rd;
                    state_reg <= (pass_reg == P_SCAN) ? S_EMIT : S_LIST;
                end
                // Start of a vertex's adjacency list
                S_LIST:
                begin
                    eu_reg <= ear_rd;
                    lu_reg <= lat_rd;
                    if (list_valid_reg[u_reg])
                    begin
                        e_reg     <= list_first;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        state_reg <= S_ORD_RD;
                    end
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_V;
                end
                S_WALK_V:
                begin
                    v_reg  <= v_rd;
                    w_reg  <= w_rd;
                    hn_reg <= hn_rd;
                    nx_reg <= nx_rd;
                    if (v_ok)
                    begin
                        state_reg <= S_WALK_UP;
                    end
                    else if (hn_rd)
                    begin
                        e_reg     <= nx_rd;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        state_reg <= S_ORD_RD;
                    end
                end
                // Per-pass update of the head vertex (of the source vertex in the backward pass)
                S_WALK_UP:
                begin
                    if ((pass_reg == P_TOPO) && push_ok)
                    begin
                        tail_reg <= tail_reg + VW'(1);
                    end
                    if ((pass_reg == P_FWD) && (cand_e > ear_rd) && (cand_e > total_reg))
                    begin
                        total_reg <= cand_e;
                    end
                    if (pass_reg == P_BWD)
                    begin
                        lu_reg <= lu_upd;
                    end
                    if (hn_reg)
                    begin
                        e_reg     <= nx_reg;
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        state_reg <= S_ORD_RD;
                    end
                end
                S_EINIT:
                begin
                    if (idx_reg == n_act)
                    begin
                        idx_reg   <= '0;
                        total_reg <= '0;
                        pass_reg  <= P_FWD;
                        state_reg <= S_ORD_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + VW'(1);
                    end
                end
                S_LINIT:
                begin
                    if (idx_reg == n_act)
                    begin
                        pass_reg  <= P_BWD;
                        state_reg <= S_ORD_RD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + VW'(1);
                    end
                end
                // Critical check; hold one result back to mark the last
                S_EMIT:
                begin
                    if (ear_rd == lat_rd)
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_reg <= 1'b1;
                            ev_reg     <= cpe_pkg::VERTEX_W'(XW'(pend_reg));
                            status_reg <= cpe_pkg::STATUS_OK;
                            last_reg   <= 1'b0;
                        end
                        pend_reg       <= u_reg;
                        pend_valid_reg <= 1'b1;
                    end
                    state_reg <= S_ORD_RD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign event_vertex  = ev_reg;
    assign status        = status_reg;
    assign last          = last_reg;

    // Memories
    cpe_ram #(.WIDTH(2*EW), .DEPTH(VD), .AW(VW)) u_list (
        .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
        .raddr(list_raddr), .rdata(list_rd));
    cpe_ram #(.WIDTH(CW), .DEPTH(VD), .AW(VW)) u_deg (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rd));
    cpe_ram #(.WIDTH(VW+WB), .DEPTH(MAX_EDGES), .AW(EW)) u_edata (
        .clk(clk), .we(data_we), .waddr(used_reg[EW-1:0]), .wdata(data_wdata),
        .raddr(e_reg), .rdata(data_rd));
    cpe_ram #(.WIDTH(EW+1), .DEPTH(MAX_EDGES), .AW(EW)) u_elink (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(e_reg), .rdata(link_rd));
    cpe_ram #(.WIDTH(CW), .DEPTH(VD), .AW(VW)) u_dwork (
        .clk(clk), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata),
        .raddr(v_rd), .rdata(dw_rd));
    cpe_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES), .AW(TAW)) u_topo (
        .clk(clk), .we(topo_we), .waddr(topo_waddr), .wdata(topo_wdata),
        .raddr(topo_raddr), .rdata(topo_rd));
    cpe_ram #(.WIDTH(TW), .DEPTH(VD), .AW(VW)) u_ear (
        .clk(clk), .we(ear_we), .waddr(ear_waddr), .wdata(ear_wdata),
        .raddr(vt_raddr), .rdata(ear_rd));
    cpe_ram #(.WIDTH(TW), .DEPTH(VD), .AW(VW)) u_lat (
        .clk(clk), .we(lat_we), .waddr(lat_waddr), .wdata(lat_wdata),
        .raddr(vt_raddr), .rdata(lat_rd));

    // Checks
    a_cycle_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (status == cpe_pkg::STATUS_CYCLE)) |-> (last && (event_vertex == '0)))
        else $error("cycle result malformed");
    a_edges_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_EDGES))
        else $error("edge count overflow");
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result without compute run");
    a_tail_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= VW'(MAX_VERTICES))
        else $error("topological queue overflow");

endmodule

`default_nettype wire

// File: design/cpe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpe_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: tb/sv/cpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpe_checker
// Watches the item and result channels of the critical path event engine,
// keeps a shadow graph, predicts critical vertices per compute item and
// compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module cpe_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic                            cmd,
    input  wire logic [cpe_pkg::VERTEX_W-1:0]    src_vertex,
    input  wire logic [cpe_pkg::VERTEX_W-1:0]    dst_vertex,
    input  wire logic [cpe_pkg::WEIGHT_IN_W-1:0] edge_weight,
    input  wire logic                            cfg_we,
    input  wire logic [cpe_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            result_strobe,
    input  wire logic [cpe_pkg::VERTEX_W-1:0]    event_vertex,
    input  wire logic                            status,
    input  wire logic                            last,
    output int                                   fail_count,
    output int                                   pending_events
);
    localparam int NV = 32;
    localparam int NE = 256;

    typedef struct packed {
        logic [cpe_pkg::VERTEX_W-1:0] vertex;
        logic                         stat;
        logic                         fin;
    } event_t;

    // shadow graph
    logic [5:0]  head_mem [NE];
    logic [15:0] wgt_mem  [NE];
    int          next_mem [NE];   // -1 ends a list
    int          first_edge [NV+1];
    int          last_edge  [NV+1];
    int          indeg      [NV+1];
    int          edge_cnt;
    logic [5:0]  vcount_reg;
    event_t      event_queue [$];

    function automatic int live_count();
        int c;
        c = int'(vcount_reg);
        if (c < 1) return 1;
        if (c > NV) return NV;
        return c;
    endfunction

    task automatic store_edge(int s, int t, logic [15:0] w);
        int n;
        n = live_count();
        if (s < 1 || s > n || t < 1 || t > n || edge_cnt >= NE) return;
        head_mem[edge_cnt] = 6'(t);
        wgt_mem[edge_cnt]  = w;
        next_mem[edge_cnt] = -1;
        if (first_edge[s] < 0) first_edge[s] = edge_cnt;
        else next_mem[last_edge[s]] = edge_cnt;
        last_edge[s] = edge_cnt;
        indeg[t]++;
        edge_cnt++;
    endtask

    // topological sort, then earliest/latest event times
    task automatic predict_critical();
        int n, hd, tl, u, v, e, i;
        longint total;
        int deg [NV+1];
        int order [NV];
        longint early [NV+1];
        longint late [NV+1];
        event_t ev;
        n = live_count();
        hd = 0;
        tl = 0;
        for (i = 0; i <= NV; i++) deg[i] = indeg[i];
        for (u = 1; u <= n; u++)
            if (deg[u] == 0) begin order[tl] = u; tl++; end
        while (hd < tl) begin
            u = order[hd];
            hd++;
            for (e = first_edge[u]; e >= 0; e = next_mem[e]) begin
                v = int'(head_mem[e]);
                if (v >= 1 && v <= n && deg[v] > 0) begin
                    deg[v]--;
                    if (deg[v] == 0 && tl < NV) begin order[tl] = v; tl++; end
                end
            end
        end
        if (hd != n) begin
            ev.vertex = '0;
            ev.stat = cpe_pkg::STATUS_CYCLE;
            ev.fin = 1'b1;
            event_queue.push_back(ev);
            return;
        end
        for (i = 0; i <= NV; i++) early[i] = 0;
        for (i = 0; i < n; i++) begin
            u = order[i];
            for (e = first_edge[u]; e >= 0; e = next_mem[e]) begin
                v = int'(head_mem[e]);
                if (v >= 1 && v <= n && early[u] + longint'(wgt_mem[e]) > early[v])
                    early[v] = early[u] + longint'(wgt_mem[e]);
            end
        end
        total = 0;
        for (i = 1; i <= n; i++) if (early[i] > total) total = early[i];
        for (i = 0; i <= NV; i++) late[i] = total;
        for (i = n - 1; i >= 0; i--) begin
            u = order[i];
            for (e = first_edge[u]; e >= 0; e = next_mem[e]) begin
                v = int'(head_mem[e]);
                if (v >= 1 && v <= n && late[v] - longint'(wgt_mem[e]) < late[u])
                    late[u] = late[v] - longint'(wgt_mem[e]);
            end
        end
        tl = event_queue.size();
        for (i = 0; i < n; i++) begin
            u = order[i];
            if (early[u] == late[u]) begin
                ev.vertex = cpe_pkg::VERTEX_W'(u);
                ev.stat = cpe_pkg::STATUS_OK;
                ev.fin = 1'b0;
                event_queue.push_back(ev);
            end
        end
        if (event_queue.size() > tl) event_queue[event_queue.size()-1].fin = 1'b1;
    endtask

    assign pending_events = event_queue.size();

    // watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        event_t exp_ev;
        if (!rst_n)
        begin
            vcount_reg <= 6'd32;
            edge_cnt = 0;
            fail_count <= 0;
            for (int i = 0; i <= NV; i++)
            begin
                first_edge[i] = -1;
                last_edge[i] = -1;
                indeg[i] = 0;
            end
            event_queue.delete();
        end
        else
        begin
            if (result_strobe)
            begin
                if (event_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: vertex %0d status %0d last %0d",
                                 event_vertex, status, last);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_ev = event_queue.pop_front();
                    if (exp_ev.vertex !== event_vertex || exp_ev.stat !== status ||
                        exp_ev.fin !== last)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp v%0d s%0d l%0d got v%0d s%0d l%0d",
                                     exp_ev.vertex, exp_ev.stat, exp_ev.fin,
                                     event_vertex, status, last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd == cpe_pkg::CMD_ADD_EDGE)
                    store_edge(int'(src_vertex), int'(dst_vertex), edge_weight);
                else predict_critical();
            end
            if (cfg_we) vcount_reg <= cfg_wdata;
        end
    end
endmodule

// File: tb/sv/tb_critical_path_events.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_critical_path_events
// Drives edge and compute items with random gaps over several vertex counts,
// pausing for all results before each count change; the checker predicts.
// ----------------------------------------------------------------------------
module tb_critical_path_events;

    localparam int WATCHDOG = 200000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            cmd = cpe_pkg::CMD_ADD_EDGE;
    logic [cpe_pkg::VERTEX_W-1:0]    src_vertex = '0;
    logic [cpe_pkg::VERTEX_W-1:0]    dst_vertex = '0;
    logic [cpe_pkg::WEIGHT_IN_W-1:0] edge_weight = '0;
    logic                            cfg_we = 1'b0;
    logic [cpe_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                            busy, result_strobe, status, last;
    logic [cpe_pkg::VERTEX_W-1:0]    event_vertex;
    int                              fail_count, pending_events;
    int                              idle_cycles = 0;

    always #5 clk = ~clk;

    critical_path_events u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .src_vertex(src_vertex), .dst_vertex(dst_vertex), .edge_weight(edge_weight),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_strobe(result_strobe),
        .event_vertex(event_vertex), .status(status), .last(last)
    );

    cpe_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .src_vertex(src_vertex), .dst_vertex(dst_vertex), .edge_weight(edge_weight),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_strobe(result_strobe),
        .event_vertex(event_vertex), .status(status), .last(last),
        .fail_count(fail_count), .pending_events(pending_events)
    );

    // watchdog: cycles with no item and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("critical_path_events verification failed");
            $finish;
        end
    end

    // present one item and hold it until accepted, then random gap
    task automatic send_item(logic c, int s, int d, int w);
        int gap;
        start <= 1'b1;
        cmd <= c;
        src_vertex <= cpe_pkg::VERTEX_W'(s);
        dst_vertex <= cpe_pkg::VERTEX_W'(d);
        edge_weight <= cpe_pkg::WEIGHT_IN_W'(w);
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain results, let the block settle, then write the vertex count
    task automatic set_count(int value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_events != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        while (busy) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cpe_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random graph edges with mostly valid endpoints, mixed with compute items
    task automatic random_phase(int n, int items);
        int r;
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8) send_item(cpe_pkg::CMD_COMPUTE, $urandom_range(0, 63),
                                 $urandom_range(0, 63), $urandom_range(0, 65535));
            else if (r < 14) send_item(cpe_pkg::CMD_ADD_EDGE, $urandom_range(0, 63),
                                       $urandom_range(0, 63), $urandom);
            else
            begin
                // forward edges keep the graph acyclic most of the time
                int a, b;
                a = $urandom_range(1, n);
                b = $urandom_range(1, n);
                if ($urandom_range(0, 19) != 0 && a > b) begin int t; t = a; a = b; b = t; end
                send_item(cpe_pkg::CMD_ADD_EDGE, a, b,
                          ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20));
            end
        end
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty graph, chain, parallel paths, bad endpoints, cycle
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        send_item(cpe_pkg::CMD_ADD_EDGE, 1, 2, 16'hFFFF);
        send_item(cpe_pkg::CMD_ADD_EDGE, 2, 32, 0);
        send_item(cpe_pkg::CMD_ADD_EDGE, 1, 3, 5);
        send_item(cpe_pkg::CMD_ADD_EDGE, 3, 32, 1);
        send_item(cpe_pkg::CMD_ADD_EDGE, 0, 4, 7);
        send_item(cpe_pkg::CMD_ADD_EDGE, 4, 0, 7);
        send_item(cpe_pkg::CMD_ADD_EDGE, 33, 4, 7);
        send_item(cpe_pkg::CMD_ADD_EDGE, 63, 63, 16'hFFFF);
        send_item(cpe_pkg::CMD_COMPUTE, 63, 63, 16'hFFFF);
        send_item(cpe_pkg::CMD_ADD_EDGE, 32, 1, 3);
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        // shrink count: edges from vertex 32 never walked, head 1 stays pending
        set_count(4);
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        set_count(0);
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        set_count(63);
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        // a fresh acyclic graph cannot be rebuilt without reset; sweep counts
        set_count(1);
        send_item(cpe_pkg::CMD_ADD_EDGE, 1, 1, 2);
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        set_count(32);
        random_phase(32, 90);
        set_count(8);
        random_phase(8, 80);
        set_count(20);
        random_phase(20, 90);
        // overflow the edge store
        set_count(32);
        for (int k = 0; k < 60; k++) send_item(cpe_pkg::CMD_ADD_EDGE, 5, 6, k);
        send_item(cpe_pkg::CMD_COMPUTE, 0, 0, 0);
        start <= 1'b0;
        @(posedge clk);
        while (pending_events != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0) $display("critical_path_events verification clean");
        else $display("critical_path_events verification failed");
        $finish;
    end
endmodule

// File: files.f
design/cpe_pkg.sv
design/cpe_ram.sv
design/critical_path_events.sv
tb/sv/cpe_checker.sv
tb/sv/tb_critical_path_events.sv
